/* src/gsrc_pkg.sv */
// ----------------------------------------------------------------------------
// gsrc_pkg
// Types, constants and the CRC-32C byte step for the guard sector checker.
// ----------------------------------------------------------------------------
`default_nettype none
package gsrc_pkg;

    localparam logic [31:0] CRC_POLY        = 32'h82F6_3B78;
    localparam logic [31:0] CRC_SEED        = 32'hFFFF_FFFF;
    localparam logic [31:0] HDR_MAGIC       = 32'h4D58_4C4B;
    localparam logic [31:0] HDR_FLAG_GUARD  = 32'h0000_0003;
    localparam logic [31:0] DESC_MAGIC      = 32'h5643_524D;
    localparam logic [31:0] OC_MAGIC_WORD   = 32'h4F43_5652;
    localparam logic [15:0] OC_VERSION_WORD = 16'h0001;
    localparam logic [15:0] DESC_VER_RESET  = 16'd3;
    localparam logic [8:0]  LAST_POS        = 9'd511;
    localparam logic [8:0]  DESC_END_POS    = 9'd155;
    localparam logic [8:0]  OC_END_POS      = 9'd251;

    typedef enum logic [2:0] {
        VD_NO_DESC     = 3'd0,
        VD_BAD_SHAPE   = 3'd1,
        VD_LIVE        = 3'd2,
        VD_RECORD      = 3'd3,
        VD_BAD_OUTCOME = 3'd4,
        VD_NO_OUTCOME  = 3'd5
    } t_verdict;

    typedef struct packed {
        logic        desc_found;
        logic        desc_crc_ok;
        logic        desc_version_ok;
        logic        quarantined;
        logic        outcome_present;
        logic        outcome_valid;
        logic [31:0] sector_crc;
    } t_summary;

    // reflected CRC-32C, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* src/gsrc_if.sv */
// ----------------------------------------------------------------------------
// gsrc_byte_if / gsrc_verdict_if
// Valid/ready channels for sector bytes and verdicts.
// ----------------------------------------------------------------------------
`default_nettype none
interface gsrc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_sector;
    modport source (output valid, output data_byte, output start_of_sector, input ready);
    modport sink   (input valid, input data_byte, input start_of_sector, output ready);
endinterface

interface gsrc_verdict_if;
    logic        valid;
    logic        ready;
    logic [2:0]  verdict;
    logic        desc_found;
    logic        desc_crc_ok;
    logic        desc_version_ok;
    logic        quarantined;
    logic        outcome_present;
    logic        outcome_valid;
    logic [31:0] sector_crc;
    modport source (output valid, output verdict, output desc_found, output desc_crc_ok,
                    output desc_version_ok, output quarantined, output outcome_present,
                    output outcome_valid, output sector_crc, input ready);
    modport sink   (input valid, input verdict, input desc_found, input desc_crc_ok,
                    input desc_version_ok, input quarantined, input outcome_present,
                    input outcome_valid, input sector_crc, output ready);
endinterface
`default_nettype wire

/* src/gsrc_front.sv */
// ----------------------------------------------------------------------------
// gsrc_front
// Byte intake: position tracking, CRC runs, field capture, identity fold.
// ----------------------------------------------------------------------------
`default_nettype none
module gsrc_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire  [15:0]          i_cfg_data,
    input  wire                  i_valid,
    input  wire  [7:0]           i_data_byte,
    input  wire                  i_start_of_sector,
    output logic                 o_ready,
    input  wire                  i_q_ready,
    output logic                 o_q_valid,
    output gsrc_pkg::t_summary   o_q_data
);

    logic [15:0]  r_exp_ver;
    logic [8:0]   r_pos;
    logic [31:0]  r_sec, r_desc, r_oc;
    logic         r_nz;
    logic [31:0]  r_hmagic, r_hflags, r_dmagic, r_vers, r_dcrc, r_omagic, r_ocrc;
    logic         r_quar;
    logic [127:0] r_id;
    logic [31:0]  r_desc_fin, r_oc_fin;
    logic         r_fold_busy, r_fold_sel;
    logic [3:0]   r_fold_cnt;
    logic [31:0]  r_fold_crc;

    logic         acc;
    logic [8:0]   p;
    logic         first;
    logic [31:0]  n_sec, n_desc, n_oc;
    logic         n_nz;
    logic [3:0]   id_idx;
    logic [1:0]   lane;
    logic         dpres;

    assign o_ready = i_q_ready;
    assign acc     = i_valid && o_ready;
    assign p       = i_start_of_sector ? 9'd0 : r_pos;
    assign first   = (p == 9'd0);
    assign lane    = p[1:0];
    assign id_idx  = (p < 9'd16) ? {1'b0, ~p[2], p[1:0]} : {1'b1, p[2], p[1:0]};

    always_comb begin
        n_sec  = gsrc_pkg::crc_byte(first ? gsrc_pkg::CRC_SEED : r_sec, i_data_byte);
        n_desc = first ? gsrc_pkg::CRC_SEED : r_desc;
        n_oc   = first ? gsrc_pkg::CRC_SEED : r_oc;
        n_nz   = first ? 1'b0 : r_nz;
        if (p >= 9'd40 && p <= 9'd155) begin
            n_desc = gsrc_pkg::crc_byte(n_desc, i_data_byte);
        end
        if (p >= 9'd160 && p <= 9'd251) begin
            n_oc = gsrc_pkg::crc_byte(n_oc, i_data_byte);
        end
        if (p >= 9'd160 && p <= 9'd255 && i_data_byte != 8'd0) begin
            n_nz = 1'b1;
        end
    end

    assign dpres = (r_hmagic == gsrc_pkg::HDR_MAGIC) && (r_hflags == gsrc_pkg::HDR_FLAG_GUARD)
                && (r_dmagic == gsrc_pkg::DESC_MAGIC);

    assign o_q_valid = acc && (p == gsrc_pkg::LAST_POS);
    always_comb begin
        o_q_data.desc_found      = dpres;
        o_q_data.desc_crc_ok     = dpres && (r_dcrc == r_desc_fin);
        o_q_data.desc_version_ok = (r_vers[15:0] == r_exp_ver);
        o_q_data.quarantined     = r_quar;
        o_q_data.outcome_present = r_nz;
        o_q_data.outcome_valid   = dpres && (r_omagic == gsrc_pkg::OC_MAGIC_WORD)
                                && (r_vers[31:16] == gsrc_pkg::OC_VERSION_WORD)
                                && (r_ocrc == r_oc_fin);
        o_q_data.sector_crc      = n_sec;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_ver   <= gsrc_pkg::DESC_VER_RESET;
            r_pos       <= 9'd0;
            r_fold_busy <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_exp_ver <= i_cfg_data;
            end
            if (acc) begin
                r_pos <= (p == gsrc_pkg::LAST_POS) ? 9'd0 : p + 9'd1;
            end
            if (acc && (p == gsrc_pkg::DESC_END_POS || p == gsrc_pkg::OC_END_POS)) begin
                r_fold_busy <= 1'b1;
            end else if (r_fold_busy && r_fold_cnt == 4'd15) begin
                r_fold_busy <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_sec  <= n_sec;
            r_desc <= n_desc;
            r_oc   <= n_oc;
            r_nz   <= n_nz;
            case (p) inside
                [9'd0:9'd3]:     r_hmagic[lane*8 +: 8] <= i_data_byte;
                [9'd4:9'd7]:     r_hflags[lane*8 +: 8] <= i_data_byte;
                [9'd8:9'd15],
                [9'd24:9'd31]:   r_id[id_idx*8 +: 8]   <= i_data_byte;
                [9'd40:9'd43]:   r_dmagic[lane*8 +: 8] <= i_data_byte;
                [9'd44:9'd45]:   r_vers[lane*8 +: 8]   <= i_data_byte;
                9'd92:           r_quar                <= i_data_byte[0];
                [9'd156:9'd159]: r_dcrc[lane*8 +: 8]   <= i_data_byte;
                [9'd160:9'd163]: r_omagic[lane*8 +: 8] <= i_data_byte;
                // outcome version lands in the upper half of the version word
                9'd164:          r_vers[23:16]         <= i_data_byte;
                9'd165:          r_vers[31:24]         <= i_data_byte;
                [9'd252:9'd255]: r_ocrc[lane*8 +: 8]   <= i_data_byte;
                default: ;
            endcase
        end
        // side engine: one identity byte a cycle, all 16 identity bytes
        if (acc && (p == gsrc_pkg::DESC_END_POS || p == gsrc_pkg::OC_END_POS)) begin
            r_fold_sel <= (p == gsrc_pkg::OC_END_POS);
            r_fold_cnt <= 4'd0;
            r_fold_crc <= (p == gsrc_pkg::OC_END_POS) ? n_oc : n_desc;
        end else if (r_fold_busy) begin
            r_fold_cnt <= r_fold_cnt + 4'd1;
            r_fold_crc <= gsrc_pkg::crc_byte(r_fold_crc, r_id[r_fold_cnt*8 +: 8]);
            if (r_fold_cnt == 4'd15) begin
                if (r_fold_sel) begin
                    r_oc_fin <= gsrc_pkg::crc_byte(r_fold_crc, r_id[r_fold_cnt*8 +: 8]);
                end else begin
                    r_desc_fin <= gsrc_pkg::crc_byte(r_fold_crc, r_id[r_fold_cnt*8 +: 8]);
                end
            end
        end
    end

endmodule
`default_nettype wire

/* src/gsrc_queue.sv */
// ----------------------------------------------------------------------------
// gsrc_queue
// Two-entry queue of sector summaries between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module gsrc_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  gsrc_pkg::t_summary   i_data,
    output logic                 o_ready,
    output logic                 o_valid,
    output gsrc_pkg::t_summary   o_data,
    input  wire                  i_ready
);

    gsrc_pkg::t_summary r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule
`default_nettype wire

/* src/gsrc_back.sv */
// ----------------------------------------------------------------------------
// gsrc_back
// Verdict decision and output register.
// ----------------------------------------------------------------------------
`default_nettype none
module gsrc_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  gsrc_pkg::t_summary   i_data,
    output logic                 o_ready,
    gsrc_verdict_if.source       o_out
);

    logic               r_valid;
    gsrc_pkg::t_summary r_sum;
    gsrc_pkg::t_verdict r_verdict;
    gsrc_pkg::t_verdict n_verdict;

    assign o_ready = !r_valid || o_out.ready;

    always_comb begin
        if (!i_data.desc_found) begin
            n_verdict = gsrc_pkg::VD_NO_DESC;
        end else if (!(i_data.desc_crc_ok && i_data.desc_version_ok)) begin
            n_verdict = gsrc_pkg::VD_BAD_SHAPE;
        end else if (!i_data.quarantined) begin
            n_verdict = gsrc_pkg::VD_LIVE;
        end else if (i_data.outcome_valid) begin
            n_verdict = gsrc_pkg::VD_RECORD;
        end else if (i_data.outcome_present) begin
            n_verdict = gsrc_pkg::VD_BAD_OUTCOME;
        end else begin
            n_verdict = gsrc_pkg::VD_NO_OUTCOME;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sum     <= i_data;
            r_verdict <= n_verdict;
        end
    end

    assign o_out.valid           = r_valid;
    assign o_out.verdict         = r_verdict;
    assign o_out.desc_found      = r_sum.desc_found;
    assign o_out.desc_crc_ok     = r_sum.desc_crc_ok;
    assign o_out.desc_version_ok = r_sum.desc_version_ok;
    assign o_out.quarantined     = r_sum.quarantined;
    assign o_out.outcome_present = r_sum.outcome_present;
    assign o_out.outcome_valid   = r_sum.outcome_valid;
    assign o_out.sector_crc      = r_sum.sector_crc;

endmodule
`default_nettype wire

/* src/guard_sector_record_checker.sv */
// The last byte's summary passes through the summary queue and the verdict output register.
// Throughput: one byte per cycle while the summary queue has room; a 512-byte sector yields one verdict.
// The identity fold runs on a side CRC engine after bytes 155 and 251.
// Reset (synchronous, active low) empties the queue and output, sets position to 0
// and the expected descriptor version to 3.
// ----------------------------------------------------------------------------
// guard_sector_record_checker
// Heartbeat guard sector checker: byte intake, summary queue, verdict stage.
// ----------------------------------------------------------------------------
`default_nettype none
module guard_sector_record_checker (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_cfg_we,
    input  wire  [15:0]    i_cfg_data,
    gsrc_byte_if.sink      i_byte,
    gsrc_verdict_if.source o_verdict
);

    logic               f_valid, f_ready, b_valid, b_ready;
    gsrc_pkg::t_summary f_data, b_data;

    gsrc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_byte.valid),
        .i_data_byte      (i_byte.data_byte),
        .i_start_of_sector(i_byte.start_of_sector),
        .o_ready          (i_byte.ready),
        .i_q_ready        (f_ready),
        .o_q_valid        (f_valid),
        .o_q_data         (f_data)
    );

    gsrc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_data  (f_data),
        .o_ready (f_ready),
        .o_valid (b_valid),
        .o_data  (b_data),
        .i_ready (b_ready)
    );

    gsrc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (b_valid),
        .i_data  (b_data),
        .o_ready (b_ready),
        .o_out   (o_verdict)
    );

endmodule
`default_nettype wire

/* tb/guard_sector_record_checker_test.sv */
// ----------------------------------------------------------------------------
// guard_sector_record_checker_test
// Streams heartbeat sectors into the checker and compares every verdict with a
// behavioural predictor. Directed sectors from a table, then random sectors.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module guard_sector_record_checker_test;

    typedef struct packed {
        logic [2:0]  verdict;
        logic        desc_found;
        logic        desc_crc_ok;
        logic        desc_version_ok;
        logic        quarantined;
        logic        outcome_present;
        logic        outcome_valid;
        logic [31:0] sector_crc;
    } t_verdict_rec;

    // sector kinds used by the table and the random part
    typedef enum int {
        SK_ZERO, SK_RECORD, SK_LIVE, SK_BADCRC, SK_BADVER, SK_BADOC, SK_NOOC,
        SK_NOHDR, SK_ONES, SK_NOISE, SK_TRUNC
    } t_kind;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [15:0] cfg_data;
    gsrc_byte_if    byte_ch ();
    gsrc_verdict_if vd_ch ();

    guard_sector_record_checker u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_byte(byte_ch.sink), .o_verdict(vd_ch.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // predictor state
    logic [15:0] pr_exp_ver;
    logic [8:0]  pr_pos;
    logic [31:0] pr_ident [4];
    logic [31:0] pr_scrc, pr_dcrc, pr_ocrc;
    logic [31:0] pr_cap [8];
    logic        pr_nz;

    t_verdict_rec verdicts_due [$];
    int  fail_cnt = 0;
    int  idle_cnt = 0;
    bit  recv_on  = 1'b0;
    logic [7:0] sec [512];

    function automatic logic [31:0] crc8(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ 32'h82F63B78) : (r >> 1);
        return r;
    endfunction

    function automatic logic [31:0] fold_ident(input logic [31:0] c);
        logic [31:0] r;
        r = c;
        for (int w = 0; w < 4; w++)
            for (int k = 0; k < 4; k++) r = crc8(r, pr_ident[w][8*k +: 8]);
        return r;
    endfunction

    task automatic predict_byte(input logic [7:0] b, input logic sos);
        logic [8:0] p;
        t_verdict_rec v;
        bit dp, dc, dv, q, ov;
        if (sos) pr_pos = '0;
        p = pr_pos;
        if (p == 0) begin
            pr_scrc = '1; pr_dcrc = '1; pr_ocrc = '1; pr_nz = 1'b0;
        end
        pr_scrc = crc8(pr_scrc, b);
        if (p >= 40 && p <= 155) pr_dcrc = crc8(pr_dcrc, b);
        if (p >= 160 && p <= 251) pr_ocrc = crc8(pr_ocrc, b);
        if (p >= 160 && p <= 255 && b != 0) pr_nz = 1'b1;
        if (p <= 3) pr_cap[0][8*p[1:0] +: 8] = b;
        else if (p <= 7) pr_cap[1][8*p[1:0] +: 8] = b;
        else if (p <= 11) pr_ident[1][8*p[1:0] +: 8] = b;
        else if (p <= 15) pr_ident[0][8*p[1:0] +: 8] = b;
        else if (p >= 24 && p <= 31) pr_ident[p <= 27 ? 2 : 3][8*p[1:0] +: 8] = b;
        else if (p >= 40 && p <= 43) pr_cap[2][8*p[1:0] +: 8] = b;
        else if (p == 44 || p == 45) pr_cap[3][8*p[1:0] +: 8] = b;
        else if (p >= 92 && p <= 95) pr_cap[4][8*p[1:0] +: 8] = b;
        else if (p >= 156 && p <= 159) pr_cap[5][8*p[1:0] +: 8] = b;
        else if (p >= 160 && p <= 163) pr_cap[6][8*p[1:0] +: 8] = b;
        else if (p == 164 || p == 165) pr_cap[3][8*(p[1:0] + 2) +: 8] = b;
        else if (p >= 252 && p <= 255) pr_cap[7][8*p[1:0] +: 8] = b;
        if (p == 155) pr_dcrc = fold_ident(pr_dcrc);
        if (p == 251) pr_ocrc = fold_ident(pr_ocrc);
        if (p == 511) begin
            dp = pr_cap[0] == gsrc_pkg::HDR_MAGIC && pr_cap[1] == gsrc_pkg::HDR_FLAG_GUARD &&
                 pr_cap[2] == gsrc_pkg::DESC_MAGIC;
            dc = dp && pr_cap[5] == pr_dcrc;
            dv = pr_cap[3][15:0] == pr_exp_ver;
            q  = pr_cap[4][0];
            ov = dp && pr_cap[6] == gsrc_pkg::OC_MAGIC_WORD &&
                 pr_cap[3][31:16] == gsrc_pkg::OC_VERSION_WORD && pr_cap[7] == pr_ocrc;
            if (!dp) v.verdict = gsrc_pkg::VD_NO_DESC;
            else if (!(dc && dv)) v.verdict = gsrc_pkg::VD_BAD_SHAPE;
            else if (!q) v.verdict = gsrc_pkg::VD_LIVE;
            else if (ov) v.verdict = gsrc_pkg::VD_RECORD;
            else if (pr_nz) v.verdict = gsrc_pkg::VD_BAD_OUTCOME;
            else v.verdict = gsrc_pkg::VD_NO_OUTCOME;
            v.desc_found = dp; v.desc_crc_ok = dc; v.desc_version_ok = dv;
            v.quarantined = q; v.outcome_present = pr_nz; v.outcome_valid = ov;
            v.sector_crc = pr_scrc;
            verdicts_due.push_back(v);
            pr_pos = '0;
        end else begin
            pr_pos = p + 9'd1;
        end
    endtask

    task automatic put_word(input int off, input logic [31:0] w);
        for (int k = 0; k < 4; k++) sec[off + k] = w[8*k +: 8];
    endtask

    // builds a sector of the given kind in sec[]
    task automatic build_sector(input t_kind kind, input logic [15:0] ver, input bit rnd);
        logic [31:0] c;
        for (int i = 0; i < 512; i++) sec[i] = rnd ? 8'($urandom) : 8'h00;
        if (kind == SK_ONES) begin
            for (int i = 0; i < 512; i++) sec[i] = 8'hFF;
            return;
        end
        if (kind == SK_ZERO || kind == SK_NOISE || kind == SK_TRUNC) return;
        put_word(0, kind == SK_NOHDR ? gsrc_pkg::HDR_MAGIC ^ (32'd1 << $urandom_range(31, 0))
                                     : gsrc_pkg::HDR_MAGIC);
        put_word(4, gsrc_pkg::HDR_FLAG_GUARD);
        put_word(40, gsrc_pkg::DESC_MAGIC);
        sec[44] = ver[7:0]; sec[45] = kind == SK_BADVER ? ~ver[15:8] : ver[15:8];
        sec[92][0] = (kind != SK_LIVE);
        c = '1;
        for (int i = 40; i <= 155; i++) c = crc8(c, sec[i]);
        for (int w = 0; w < 4; w++)
            for (int k = 0; k < 4; k++)
                c = crc8(c, sec[(w == 0 ? 12 : w == 1 ? 8 : w == 2 ? 24 : 28) + k]);
        put_word(156, kind == SK_BADCRC ? c ^ 32'h0000_0100 : c);
        if (kind == SK_NOOC) begin
            for (int i = 160; i < 256; i++) sec[i] = 8'h00;
            return;
        end
        put_word(160, gsrc_pkg::OC_MAGIC_WORD);
        sec[164] = 8'h01; sec[165] = 8'h00;
        c = '1;
        for (int i = 160; i <= 251; i++) c = crc8(c, sec[i]);
        for (int w = 0; w < 4; w++)
            for (int k = 0; k < 4; k++)
                c = crc8(c, sec[(w == 0 ? 12 : w == 1 ? 8 : w == 2 ? 24 : 28) + k]);
        put_word(252, kind == SK_BADOC ? ~c : c);
    endtask

    function automatic int gap_len();
        return ($urandom_range(9, 0) == 0) ? $urandom_range(30, 5) : $urandom_range(1, 0);
    endfunction

    // valid stays high between back-to-back bytes; it drops only for a gap
    task automatic send_byte(input logic [7:0] b, input logic sos, input bit gappy);
        int n;
        n = (gappy && $urandom_range(3, 0) == 0) ? gap_len() : 0;
        if (n > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.start_of_sector <= sos;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        predict_byte(b, sos);
    endtask

    // len < 512 gives a truncated sector; mark selects start_of_sector on byte 0
    task automatic send_sector(input int len, input bit mark, input bit gappy);
        for (int i = 0; i < len; i++) send_byte(sec[i], mark && i == 0, gappy);
    endtask

    task automatic drain();
        byte_ch.valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_version(input logic [15:0] v);
        cfg_we <= 1'b1; cfg_data <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        pr_exp_ver = v;
    endtask

    // verdict checking
    always @(posedge i_clk) begin
        t_verdict_rec exp_v;
        if (i_rst_n && vd_ch.valid && vd_ch.ready) begin
            if (verdicts_due.size() == 0) begin
                $error("verdict with nothing expected");
                fail_cnt++;
            end else begin
                exp_v = verdicts_due.pop_front();
                if (vd_ch.verdict !== exp_v.verdict) begin
                    $error("verdict exp %0d got %0d", exp_v.verdict, vd_ch.verdict);
                    fail_cnt++;
                end
                if (vd_ch.desc_found !== exp_v.desc_found) begin
                    $error("desc_found exp %0b got %0b", exp_v.desc_found,
                           vd_ch.desc_found);
                    fail_cnt++;
                end
                if (vd_ch.desc_crc_ok !== exp_v.desc_crc_ok) begin
                    $error("desc_crc_ok exp %0b got %0b", exp_v.desc_crc_ok, vd_ch.desc_crc_ok);
                    fail_cnt++;
                end
                if (vd_ch.desc_version_ok !== exp_v.desc_version_ok) begin
                    $error("desc_version_ok exp %0b got %0b", exp_v.desc_version_ok,
                           vd_ch.desc_version_ok);
                    fail_cnt++;
                end
                if (vd_ch.quarantined !== exp_v.quarantined) begin
                    $error("quarantined exp %0b got %0b", exp_v.quarantined, vd_ch.quarantined);
                    fail_cnt++;
                end
                if (vd_ch.outcome_present !== exp_v.outcome_present) begin
                    $error("outcome_present exp %0b got %0b", exp_v.outcome_present,
                           vd_ch.outcome_present);
                    fail_cnt++;
                end
                if (vd_ch.outcome_valid !== exp_v.outcome_valid) begin
                    $error("outcome_valid exp %0b got %0b", exp_v.outcome_valid,
                           vd_ch.outcome_valid);
                    fail_cnt++;
                end
                if (vd_ch.sector_crc !== exp_v.sector_crc) begin
                    $error("sector_crc exp %08h got %08h", exp_v.sector_crc, vd_ch.sector_crc);
                    fail_cnt++;
                end
            end
        end
    end

    // receiver stalls: mostly short, some long, with stall-free stretches
    initial begin
        int n;
        vd_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!recv_on) vd_ch.ready <= 1'b1;
            else if ($urandom_range(7, 0) == 0) begin
                vd_ch.ready <= 1'b0;
                n = ($urandom_range(5, 0) == 0) ? $urandom_range(60, 10) : $urandom_range(3, 1);
                repeat (n) @(posedge i_clk);
                vd_ch.ready <= 1'b1;
            end else vd_ch.ready <= 1'b1;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((byte_ch.valid && byte_ch.ready) || (vd_ch.valid && vd_ch.ready)) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= 5000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // directed table: kind, random fill, expected verdict (or -1 for predictor only)
    typedef struct {
        t_kind kind;
        bit    rnd;
        int    exp_vd;
    } t_row;

    t_row dir_tab [12] = '{
        '{SK_ZERO,   1'b0, gsrc_pkg::VD_NO_DESC},
        '{SK_ONES,   1'b0, gsrc_pkg::VD_NO_DESC},
        '{SK_RECORD, 1'b0, gsrc_pkg::VD_RECORD},
        '{SK_RECORD, 1'b1, gsrc_pkg::VD_RECORD},
        '{SK_LIVE,   1'b1, gsrc_pkg::VD_LIVE},
        '{SK_BADCRC, 1'b1, gsrc_pkg::VD_BAD_SHAPE},
        '{SK_BADVER, 1'b1, gsrc_pkg::VD_BAD_SHAPE},
        '{SK_BADOC,  1'b1, gsrc_pkg::VD_BAD_OUTCOME},
        '{SK_NOOC,   1'b0, gsrc_pkg::VD_NO_OUTCOME},
        '{SK_NOHDR,  1'b1, gsrc_pkg::VD_NO_DESC},
        '{SK_NOISE,  1'b1, -1},
        '{SK_TRUNC,  1'b1, -1}
    };

    initial begin
        t_kind k;
        int r;
        logic [15:0] vers [4];
        i_rst_n = 1'b0;
        cfg_we = 1'b0; cfg_data = '0;
        byte_ch.valid = 1'b0; byte_ch.data_byte = '0; byte_ch.start_of_sector = 1'b0;
        pr_exp_ver = gsrc_pkg::DESC_VER_RESET; pr_pos = '0;
        pr_scrc = '1; pr_dcrc = '1; pr_ocrc = '1; pr_nz = 1'b0;
        for (int i = 0; i < 4; i++) pr_ident[i] = '0;
        for (int i = 0; i < 8; i++) pr_cap[i] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first sector without a start mark, at the reset version
        build_sector(SK_RECORD, gsrc_pkg::DESC_VER_RESET, 1'b1);
        send_sector(512, 1'b0, 1'b0);
        drain();
        recv_on = 1'b1;
        for (int i = 0; i < 12; i++) begin
            build_sector(dir_tab[i].kind, pr_exp_ver, dir_tab[i].rnd);
            if (dir_tab[i].kind == SK_TRUNC) send_sector(200, 1'b1, 1'b1);
            else send_sector(512, 1'b1, 1'b1);
            if (dir_tab[i].exp_vd >= 0 && verdicts_due.size() != 0 &&
                verdicts_due[$].verdict != dir_tab[i].exp_vd) begin
                $error("verdict table exp %0d pred %0d", dir_tab[i].exp_vd,
                       verdicts_due[$].verdict);
                fail_cnt++;
            end
        end
        // start mark mid-sector drops the truncated one above
        build_sector(SK_LIVE, pr_exp_ver, 1'b1);
        send_sector(512, 1'b1, 1'b1);
        drain();

        vers = '{16'h0000, 16'hFFFF, 16'h8001, 16'h5A3C};
        for (int ph = 0; ph < 4; ph++) begin
            write_version(ph == 3 ? 16'($urandom) : vers[ph]);
            for (int s = 0; s < 3; s++) begin
                r = $urandom_range(19, 0);
                k = r < 6 ? SK_RECORD : r < 8 ? SK_LIVE : r < 10 ? SK_BADCRC :
                    r < 12 ? SK_BADVER : r < 14 ? SK_BADOC : r < 16 ? SK_NOOC :
                    r < 17 ? SK_NOHDR : r < 18 ? SK_NOISE : SK_TRUNC;
                build_sector(k, pr_exp_ver, 1'b1);
                if (k == SK_TRUNC) send_sector($urandom_range(300, 1), 1'b1, 1'b1);
                else send_sector(512, $urandom_range(3, 0) != 0 || pr_pos == 0,
                                 $urandom_range(3, 0) != 0);
            end
            // finish any partial sector with a fresh marked one
            if (pr_pos != 0) begin
                build_sector(SK_RECORD, pr_exp_ver, 1'b1);
                send_sector(512, 1'b1, 1'b1);
            end
            drain();
        end
        write_version(gsrc_pkg::DESC_VER_RESET);
        drain();
        if (fail_cnt == 0 && verdicts_due.size() == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule

/* sim.f */
src/gsrc_pkg.sv
src/gsrc_if.sv
src/gsrc_front.sv
src/gsrc_queue.sv
src/gsrc_back.sv
src/guard_sector_record_checker.sv
tb/guard_sector_record_checker_test.sv
